// ===== sv/table_linear_interpolator_core_assert.svh =====
// Assertion macros for the table interpolator core.
`ifndef TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define TLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== sv/tli_pkg.sv =====
//------------------------------------------------------------------------------
// tli_pkg
// Shared constants and types of the table interpolator.
//------------------------------------------------------------------------------
`default_nettype none
package tli_pkg;
	localparam int TABLE_DEPTH = 512;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int TW = 48;
	localparam int VW = 32;
	localparam int LRW = 9;
	localparam logic [LRW-1:0] LAST_ROW_RESET = 9'd275;
	localparam logic [AW-1:0] LAST_MAX = AW'(TABLE_DEPTH - 1);

	localparam logic       CMD_LOAD  = 1'b0;
	localparam logic       CMD_QUERY = 1'b1;
	localparam logic [1:0] ST_LOADED = 2'd0;
	localparam logic [1:0] ST_INTERP = 2'd1;
	localparam logic [1:0] ST_FIRST  = 2'd2;
	localparam logic [1:0] ST_LAST   = 2'd3;

	typedef struct packed {
		logic          cmd;
		logic [8:0]    row_index;
		logic [TW-1:0] row_temp;
		logic [VW-1:0] row_first_value;
		logic [VW-1:0] row_second_value;
		logic [TW-1:0] query_temp;
	} in_word_t;

	typedef struct packed {
		logic [VW-1:0] first_result;
		logic [VW-1:0] second_result;
		logic [1:0]    status;
	} out_word_t;

	// Queue entry between front and back: a query, or a pre-classified load.
	typedef struct packed {
		logic          is_query;
		logic          do_write;
		logic [AW-1:0] addr;
		logic [TW-1:0] temp;
		logic [VW-1:0] v1;
		logic [VW-1:0] v2;
		logic [AW-1:0] last;
	} job_t;
endpackage
`default_nettype wire

// ===== sv/tli_if.sv =====
//------------------------------------------------------------------------------
// tli_in_if / tli_out_if / tli_cfg_if
// Valid/ready channels of the table interpolator.
//------------------------------------------------------------------------------
`default_nettype none
interface tli_in_if import tli_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tli_out_if import tli_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tli_cfg_if import tli_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [LRW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/tli_front.sv =====
//------------------------------------------------------------------------------
// tli_front
// Accept words, classify loads and queries, push jobs into a two-entry queue.
//------------------------------------------------------------------------------
`default_nettype none
module tli_front import tli_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tli_in_if.sink        in_ch,
	input  wire logic [AW-1:0] last,
	output job_t          job,
	output logic          job_valid,
	input  wire logic     job_pop
);
	job_t       q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	job_t       nj;
	logic       push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_q[rd_q];

	always_comb begin
		nj.is_query = (in_ch.data.cmd == CMD_QUERY);
		// out-of-range index writes nothing
		nj.do_write = (in_ch.data.cmd == CMD_LOAD) &&
			({1'b0, in_ch.data.row_index} < 10'(TABLE_DEPTH));
		nj.addr = AW'(in_ch.data.row_index);
		nj.temp = nj.is_query ? in_ch.data.query_temp : in_ch.data.row_temp;
		nj.v1 = in_ch.data.row_first_value;
		nj.v2 = in_ch.data.row_second_value;
		nj.last = last;
	end

	always_ff @(posedge clk) begin
		if (push) q_q[rd_q ^ (cnt_q == 2'd1)] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_pop};
			if (job_pop) rd_q <= ~rd_q;
		end
	end
endmodule
`default_nettype wire

// ===== sv/tli_div.sv =====
//------------------------------------------------------------------------------
// tli_div
// Restoring divider: floor(d * n / den), one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module tli_div import tli_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [VW-1:0] d,
	input  wire logic [TW-1:0] n,
	input  wire logic [TW-1:0] den,
	output logic               busy,
	output logic [VW-1:0]      quo
);
	localparam int PW = VW + TW;
	localparam int CW = $clog2(PW + 2);
	typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_RUN} dv_t;
	dv_t             st_q;
	logic [PW-1:0]   prod_q;
	logic [TW:0]     rem_q;
	logic [CW-1:0]   cnt_q;
	logic [TW:0]     trial;
	logic [TW-1:0]   den_q;
	logic [VW-1:0]   d_q;
	logic [TW-1:0]   n_q;
	logic [2*VW-1:0] plo;
	logic [2*VW-1:0] phi;

	assign busy = (st_q != DV_IDLE);
	assign trial = {rem_q[TW-1:0], prod_q[PW-1]};
	// split the 32x48 multiply into two 32x24 halves
	assign plo = {32'd0, d_q} * {40'd0, n_q[23:0]};
	assign phi = {32'd0, d_q} * {40'd0, n_q[47:24]};

	always_ff @(posedge clk) begin
		case (st_q)
			DV_IDLE: if (start) begin
				d_q <= d;
				n_q <= n;
				den_q <= den;
				rem_q <= '0;
			end
			DV_MUL: prod_q <= PW'(plo) + (PW'(phi) << 24);
			DV_RUN: begin
				prod_q <= prod_q << 1;
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quo <= {quo[VW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo <= {quo[VW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DV_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				DV_IDLE: if (start) st_q <= DV_MUL;
				DV_MUL: begin
					st_q <= DV_RUN;
					cnt_q <= CW'(PW - 1);
				end
				DV_RUN: begin
					if (cnt_q == '0) st_q <= DV_IDLE;
					cnt_q <= cnt_q - 1'b1;
				end
				default: st_q <= DV_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/tli_back.sv =====
//------------------------------------------------------------------------------
// tli_back
// Own the table memories, run the search and the two interpolations.
//------------------------------------------------------------------------------
`default_nettype none
module tli_back import tli_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      job,
	input  wire logic job_valid,
	output logic      job_pop,
	tli_out_if.source out_ch
);
	localparam logic [3:0] B_IDLE = 4'd0, B_RD0 = 4'd1, B_CHK0 = 4'd2,
		B_RD = 4'd3, B_CHK = 4'd4, B_RDP = 4'd5, B_GETP = 4'd6,
		B_DIV1 = 4'd7, B_W1 = 4'd8, B_DIV2 = 4'd9, B_W2 = 4'd10,
		B_OUT = 4'd11, B_RDL = 4'd12, B_GETL = 4'd13;

	logic [TW-1:0] bp_mem [TABLE_DEPTH];
	logic [VW-1:0] f_mem [TABLE_DEPTH];
	logic [VW-1:0] s_mem [TABLE_DEPTH];

	logic [3:0]    st_q;
	logic [AW-1:0] raddr;
	logic [TW-1:0] bp_rd_q;
	logic [VW-1:0] f_rd_q, s_rd_q;
	logic [AW:0]   i_q;
	job_t          j_q;
	logic [TW-1:0] t1_q;
	logic [TW-1:0] t2_q;
	logic [VW-1:0] f1_q, s1_q, f2_q, s2_q;
	out_word_t     res_q;
	logic          ov_q;
	logic          dstart;
	logic [VW-1:0] dd;
	logic          dbusy;
	logic [VW-1:0] dq;
	logic          wr;

	assign wr = (st_q == B_IDLE) && job_valid && !ov_q && !job.is_query && job.do_write;
	assign job_pop = (st_q == B_IDLE) && job_valid && !ov_q;
	assign out_ch.valid = ov_q;
	assign out_ch.data = res_q;

	always_comb begin
		case (st_q)
			B_RD0:   raddr = '0;
			B_RDP:   raddr = AW'(i_q - 1'b1);
			B_RDL:   raddr = j_q.last;
			default: raddr = AW'(i_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			bp_mem[job.addr] <= job.temp;
			f_mem[job.addr] <= job.v1;
			s_mem[job.addr] <= job.v2;
		end
		bp_rd_q <= bp_mem[raddr];
		f_rd_q <= f_mem[raddr];
		s_rd_q <= s_mem[raddr];
	end

	assign dstart = (st_q == B_DIV1) || (st_q == B_DIV2);
	assign dd = (st_q == B_DIV1) ? ((f2_q >= f1_q) ? f2_q - f1_q : f1_q - f2_q)
		: ((s2_q >= s1_q) ? s2_q - s1_q : s1_q - s2_q);

	tli_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .d(dd),
		.n(j_q.temp - t1_q), .den(t2_q - t1_q), .busy(dbusy), .quo(dq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
			case (st_q)
				B_IDLE: if (job_pop) begin
					j_q <= job;
					if (job.is_query) st_q <= B_RD0;
					else begin
						res_q <= '{first_result: '0, second_result: '0, status: ST_LOADED};
						ov_q <= 1'b1;
					end
				end
				B_RD0: st_q <= B_CHK0;
				B_CHK0: begin
					if (j_q.temp >= bp_rd_q) begin
						res_q <= '{first_result: f_rd_q, second_result: s_rd_q,
							status: ST_FIRST};
						st_q <= B_OUT;
					end else if (j_q.temp == '0 || j_q.last == '0) st_q <= B_RDL;
					else begin
						i_q <= (AW+1)'(1);
						st_q <= B_RD;
					end
				end
				B_RD: st_q <= B_CHK;
				B_CHK: begin
					if (j_q.temp >= bp_rd_q) begin
						t1_q <= bp_rd_q;
						f1_q <= f_rd_q;
						s1_q <= s_rd_q;
						st_q <= B_RDP;
					end else if (i_q == {1'b0, j_q.last}) st_q <= B_RDL;
					else begin
						i_q <= i_q + 1'b1;
						st_q <= B_RD;
					end
				end
				B_RDP: st_q <= B_GETP;
				B_GETP: begin
					// upper breakpoint of the segment; the read port moves on
					t2_q <= bp_rd_q;
					f2_q <= f_rd_q;
					s2_q <= s_rd_q;
					st_q <= B_DIV1;
				end
				B_DIV1: st_q <= B_W1;
				B_W1: if (!dbusy) begin
					res_q.first_result <= (f2_q >= f1_q) ? f1_q + dq : f1_q - dq;
					st_q <= B_DIV2;
				end
				B_DIV2: st_q <= B_W2;
				B_W2: if (!dbusy) begin
					res_q.second_result <= (s2_q >= s1_q) ? s1_q + dq : s1_q - dq;
					res_q.status <= ST_INTERP;
					st_q <= B_OUT;
				end
				B_RDL: st_q <= B_GETL;
				B_GETL: begin
					res_q <= '{first_result: f_rd_q, second_result: s_rd_q, status: ST_LAST};
					st_q <= B_OUT;
				end
				B_OUT: if (!ov_q) begin
					ov_q <= 1'b1;
					st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/table_linear_interpolator_core.sv =====
// Table interpolator: a load word writes one row (breakpoint, two values) and
// answers with status 0; a query word scans rows from 0 in descending
// breakpoint order, each row via a read and a check state of the registered
// memory read port. A query at or above row 0 returns row 0; one below every
// row up to last_row returns the last row; otherwise two restoring divisions of
// 80 quotient bits run on one shared divider. A two-word queue lets the input
// run ahead of the search. No clearing pass: unwritten rows read undefined.
//------------------------------------------------------------------------------
// table_linear_interpolator_core
// Top level: config register, front classifier, back search and interpolate.
//------------------------------------------------------------------------------
`default_nettype none
`include "table_linear_interpolator_core_assert.svh"
module table_linear_interpolator_core import tli_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	tli_in_if.sink    in_ch,
	tli_out_if.source out_ch,
	tli_cfg_if.sink   cfg
);
	logic [LRW-1:0] last_row_q;
	logic [AW-1:0]  last;
	job_t           job;
	logic           job_valid;
	logic           job_pop;

	// always take register writes; clamp to the table size
	assign cfg.ready = 1'b1;
	assign last = ({1'b0, last_row_q} > (LRW+1)'(LAST_MAX)) ? LAST_MAX : AW'(last_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_row_q <= LAST_ROW_RESET;
		else if (cfg.valid) last_row_q <= cfg.data;
	end

	tli_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .last(last),
		.job(job), .job_valid(job_valid), .job_pop(job_pop)
	);

	tli_back u_back (
		.clk(clk), .arst_n(arst_n), .job(job), .job_valid(job_valid),
		.job_pop(job_pop), .out_ch(out_ch)
	);

	`TLI_ASSERT_IMP(a_pop_valid, clk, arst_n, job_pop, job_valid, "pop from empty queue")
	`TLI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.data), "result dropped while stalled")
endmodule
`default_nettype wire
